// File: design/ffa_pkg.sv
// Shared constants, codes and types of the first-fit allocator.
`timescale 1ns / 1ps
package ffa_pkg;
   // Heap geometry and fixed field widths.
   localparam int HEAP_UNITS_DEF = 4096;
   localparam int HEADER_BYTES   = 16;
   localparam int PAYLOAD_UNITS  = 4095;
   localparam int NEED_W         = 13;

   // Request commands.
   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REALLOC = 2'd2;

   // Datapath operations.
   localparam logic [3:0] DP_NOP          = 4'd0;
   localparam logic [3:0] DP_LOAD         = 4'd1;
   localparam logic [3:0] DP_READ         = 4'd2;
   localparam logic [3:0] DP_STEP         = 4'd3;
   localparam logic [3:0] DP_FOUND        = 4'd4;
   localparam logic [3:0] DP_LOCATED      = 4'd5;
   localparam logic [3:0] DP_ADD          = 4'd6;
   localparam logic [3:0] DP_GROW         = 4'd7;
   localparam logic [3:0] DP_WR_SPLIT     = 4'd8;
   localparam logic [3:0] DP_WR_NEED_USED = 4'd9;
   localparam logic [3:0] DP_WR_SPAN_USED = 4'd10;
   localparam logic [3:0] DP_WR_SUM_FREE  = 4'd11;
   localparam logic [3:0] DP_WR_OLD_USED  = 4'd12;
   localparam logic [3:0] DP_WR_REST      = 4'd13;

   // Result address selection.
   localparam logic [1:0] RSP_ZERO  = 2'd0;
   localparam logic [1:0] RSP_HIT   = 2'd1;
   localparam logic [1:0] RSP_BREAK = 2'd2;
   localparam logic [1:0] RSP_UNIT  = 2'd3;

   typedef struct packed {
      logic [3:0] op;
      logic       rsp_load;
      logic [1:0] rsp_sel;
      logic       rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic below_break;
      logic past_target;
      logic at_target;
      logic fits;
      logic used;
      logic free_nz;
      logic sum_ge_need;
      logic old_ge_need;
      logic can_split;
      logic can_grow;
      logic can_rest;
      logic addr_ok;
      logic addr_zero;
      logic bytes_zero;
   } dp_status_type;
endpackage

// File: design/ffa_datapath.sv
// Datapath of the allocator: header memory, walk registers, heap break and result register.
`timescale 1ns / 1ps
module ffa_datapath #(
   parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [16:0]           req_request_bytes,
   input  logic [15:0]           req_payload_address,
   input  ffa_pkg::dp_cmd_type   dp_cmd,
   output ffa_pkg::dp_status_type dp_status,
   output logic [15:0]           rsp_result_address,
   output logic                  rsp_status
);
   import ffa_pkg::*;

   localparam int SW = $clog2(HEAP_UNITS + 1);
   localparam int UW = $clog2(HEAP_UNITS);
   localparam int AW = ((SW > NEED_W) ? SW : NEED_W) + 1;

   // Header memory: allocated mark in the top bit, size in units below it.
   logic [SW:0] mem [HEAP_UNITS];

   logic [AW-1:0] unit_ff, unit_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] hit_ff, hit_in;
   logic [AW-1:0] need_ff, need_in;
   logic [AW-1:0] old_ff, old_in;
   logic [AW-1:0] sum_ff, sum_in;
   logic [AW-1:0] span_ff, span_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   logic [SW-1:0] brk_ff, brk_in;
   logic [SW:0]   rdata_ff;
   logic [15:0]   res_addr_ff, res_addr_in;
   logic          res_st_ff, res_st_in;

   logic [AW-1:0] rsz, brk_w, heap_w, plim_w, sum_next, need_calc, tgt_calc;
   logic [17:0]   rounded;
   logic          rused;
   logic          rd_en, wr_en;
   logic [UW-1:0] wr_addr;
   logic [SW:0]   wr_data;

   // Payload byte offset of a chunk whose header sits at the given unit.
   function automatic logic [15:0] payload_of(input logic [AW-1:0] u);
      logic [11:0] p;
      p = u[11:0] + 12'd1;
      return {p, 4'b0000};
   endfunction

   // Fields of the header just read and widened constants.
   assign rsz      = AW'(rdata_ff[SW-1:0]);
   assign rused    = rdata_ff[SW];
   assign brk_w    = AW'(brk_ff);
   assign heap_w   = AW'(HEAP_UNITS);
   assign plim_w   = AW'(PAYLOAD_UNITS);
   assign sum_next = sum_ff + rsz;

   // Units needed: rounded-up payload units plus one header unit.
   assign rounded   = {1'b0, req_request_bytes} + 18'd15;
   assign need_calc = AW'(rounded[17:4]) + AW'(1);
   assign tgt_calc  = AW'(req_payload_address[15:4]) - AW'(1);

   // Register updates and memory accesses for each operation.
   always_comb begin
      unit_in  = unit_ff;
      base_in  = base_ff;
      hit_in   = hit_ff;
      need_in  = need_ff;
      old_in   = old_ff;
      sum_in   = sum_ff;
      span_in  = span_ff;
      tgt_in   = tgt_ff;
      brk_in   = brk_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = UW'(hit_ff);
      wr_data  = {1'b1, SW'(need_ff)};
      case (dp_cmd.op)
         DP_LOAD: begin
            need_in = need_calc;
            tgt_in  = tgt_calc;
            unit_in = '0;
         end
         DP_READ: begin
            rd_en = 1'b1;
         end
         DP_STEP: begin
            unit_in = unit_ff + ((rsz != '0) ? rsz : AW'(1));
         end
         DP_FOUND: begin
            hit_in  = unit_ff;
            span_in = rsz;
         end
         DP_LOCATED: begin
            base_in = unit_ff;
            hit_in  = unit_ff;
            old_in  = rsz;
            sum_in  = rsz;
            unit_in = unit_ff + rsz;
         end
         DP_ADD: begin
            sum_in  = sum_next;
            span_in = sum_next;
            unit_in = base_ff + sum_next;
         end
         DP_GROW: begin
            wr_en   = 1'b1;
            wr_addr = UW'(brk_w);
            wr_data = {1'b1, SW'(need_ff)};
            hit_in  = brk_w;
            brk_in  = SW'(brk_w + need_ff);
         end
         DP_WR_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = UW'(hit_ff + need_ff);
            wr_data = {1'b0, SW'(span_ff - need_ff)};
         end
         DP_WR_NEED_USED: begin
            wr_en   = 1'b1;
            wr_addr = UW'(hit_ff);
            wr_data = {1'b1, SW'(need_ff)};
         end
         DP_WR_SPAN_USED: begin
            wr_en   = 1'b1;
            wr_addr = UW'(hit_ff);
            wr_data = {1'b1, SW'(span_ff)};
         end
         DP_WR_SUM_FREE: begin
            wr_en   = 1'b1;
            wr_addr = UW'(base_ff);
            wr_data = {1'b0, SW'(sum_ff)};
            unit_in = '0;
         end
         DP_WR_OLD_USED: begin
            wr_en   = 1'b1;
            wr_addr = UW'(base_ff);
            wr_data = {1'b1, SW'(old_ff)};
         end
         DP_WR_REST: begin
            wr_en   = 1'b1;
            wr_addr = UW'(base_ff + old_ff);
            wr_data = {1'b0, SW'(sum_ff - old_ff)};
         end
         default: begin
         end
      endcase
   end

   // Result register, loaded once per item.
   always_comb begin
      res_addr_in = res_addr_ff;
      res_st_in   = res_st_ff;
      if (dp_cmd.rsp_load) begin
         res_st_in = dp_cmd.rsp_status;
         case (dp_cmd.rsp_sel)
            RSP_HIT:   res_addr_in = payload_of(hit_ff);
            RSP_BREAK: res_addr_in = payload_of(brk_w);
            RSP_UNIT:  res_addr_in = payload_of(unit_ff);
            default:   res_addr_in = '0;
         endcase
      end
   end

   // Status flags for the controller.
   always_comb begin
      dp_status.below_break = unit_ff < brk_w;
      dp_status.past_target = unit_ff > tgt_ff;
      dp_status.at_target   = unit_ff == tgt_ff;
      dp_status.fits        = !rused && (rsz >= need_ff) && (unit_ff < plim_w);
      dp_status.used        = rused;
      dp_status.free_nz     = !rused && (rsz != '0);
      dp_status.sum_ge_need = sum_next >= need_ff;
      dp_status.old_ge_need = rsz >= need_ff;
      dp_status.can_split   = (span_ff > need_ff) && ((hit_ff + need_ff) < heap_w);
      dp_status.can_grow    = ((brk_w + need_ff) <= heap_w) && (brk_w < plim_w);
      dp_status.can_rest    = (sum_ff > old_ff) && ((base_ff + old_ff) < heap_w);
      dp_status.addr_ok     = (req_payload_address != 16'd0) &&
                              (req_payload_address[3:0] == 4'd0);
      dp_status.addr_zero   = req_payload_address == 16'd0;
      dp_status.bytes_zero  = req_request_bytes == 17'd0;
   end

   // Heap break is the only datapath state that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         brk_ff <= '0;
      end else begin
         brk_ff <= brk_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff     <= unit_in;
      base_ff     <= base_in;
      hit_ff      <= hit_in;
      need_ff     <= need_in;
      old_ff      <= old_in;
      sum_ff      <= sum_in;
      span_ff     <= span_in;
      tgt_ff      <= tgt_in;
      res_addr_ff <= res_addr_in;
      res_st_ff   <= res_st_in;
   end

   // Single-port header memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[UW'(unit_ff)];
      end
   end

   assign rsp_result_address = res_addr_ff;
   assign rsp_status         = res_st_ff;
endmodule

// File: design/ffa_controller.sv
// Controller state machine of the allocator: sequences walks, splits, merges and results.
`timescale 1ns / 1ps
module ffa_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffa_pkg::dp_cmd_type    dp_cmd,
   input  ffa_pkg::dp_status_type dp_status
);
   import ffa_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_A_CHK   = 4'd1;
   localparam logic [3:0] S_A_EV    = 4'd2;
   localparam logic [3:0] S_SPLIT   = 4'd3;
   localparam logic [3:0] S_MARK    = 4'd4;
   localparam logic [3:0] S_L_CHK   = 4'd5;
   localparam logic [3:0] S_L_EV    = 4'd6;
   localparam logic [3:0] S_F_CHK   = 4'd7;
   localparam logic [3:0] S_F_EV    = 4'd8;
   localparam logic [3:0] S_F_WR    = 4'd9;
   localparam logic [3:0] S_R_CHK   = 4'd10;
   localparam logic [3:0] S_R_EV    = 4'd11;
   localparam logic [3:0] S_R_MISS  = 4'd12;
   localparam logic [3:0] S_RESTORE = 4'd13;
   localparam logic [3:0] S_REST    = 4'd14;
   localparam logic [3:0] S_RESP    = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic       realloc_ff, realloc_in;
   logic [1:0] eff_cmd;

   // Reallocate without an address allocates; with zero bytes it frees.
   always_comb begin
      eff_cmd = req_command;
      if (eff_cmd == CMD_REALLOC && dp_status.addr_zero) begin
         eff_cmd = CMD_ALLOC;
      end
      if (eff_cmd == CMD_REALLOC && dp_status.bytes_zero) begin
         eff_cmd = CMD_FREE;
      end
   end

   // Next state and datapath command.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      realloc_in = realloc_ff;
      dp_cmd     = '{op: DP_NOP, rsp_load: 1'b0, rsp_sel: RSP_ZERO, rsp_status: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op  = DP_LOAD;
               cmd_in     = eff_cmd;
               realloc_in = 1'b0;
               if (eff_cmd == CMD_ALLOC) begin
                  state_in = S_A_CHK;
               end else if ((eff_cmd == CMD_FREE || eff_cmd == CMD_REALLOC) &&
                            dp_status.addr_ok) begin
                  state_in = S_L_CHK;
               end else begin
                  dp_cmd.rsp_load = 1'b1;
                  state_in        = S_RESP;
               end
            end
         end
         // First-fit walk, then growth at the break.
         S_A_CHK: begin
            if (dp_status.below_break) begin
               dp_cmd.op = DP_READ;
               state_in  = S_A_EV;
            end else if (dp_status.can_grow) begin
               dp_cmd.op       = DP_GROW;
               dp_cmd.rsp_load = 1'b1;
               dp_cmd.rsp_sel  = RSP_BREAK;
               state_in        = S_RESP;
            end else if (realloc_ff) begin
               state_in = S_RESTORE;
            end else begin
               dp_cmd.rsp_load   = 1'b1;
               dp_cmd.rsp_status = 1'b1;
               state_in          = S_RESP;
            end
         end
         S_A_EV: begin
            if (dp_status.fits) begin
               dp_cmd.op = DP_FOUND;
               state_in  = S_SPLIT;
            end else begin
               dp_cmd.op = DP_STEP;
               state_in  = S_A_CHK;
            end
         end
         // Split off a free remainder, or mark the whole chunk.
         S_SPLIT: begin
            if (dp_status.can_split) begin
               dp_cmd.op = DP_WR_SPLIT;
               state_in  = S_MARK;
            end else begin
               dp_cmd.op       = DP_WR_SPAN_USED;
               dp_cmd.rsp_load = 1'b1;
               dp_cmd.rsp_sel  = RSP_HIT;
               state_in        = S_RESP;
            end
         end
         S_MARK: begin
            dp_cmd.op       = DP_WR_NEED_USED;
            dp_cmd.rsp_load = 1'b1;
            dp_cmd.rsp_sel  = RSP_HIT;
            state_in        = S_RESP;
         end
         // Walk to the chunk named by the address.
         S_L_CHK: begin
            if (dp_status.below_break && !dp_status.past_target) begin
               dp_cmd.op = DP_READ;
               state_in  = S_L_EV;
            end else begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_RESP;
            end
         end
         S_L_EV: begin
            if (!dp_status.at_target) begin
               dp_cmd.op = DP_STEP;
               state_in  = S_L_CHK;
            end else if (!dp_status.used) begin
               dp_cmd.rsp_load = 1'b1;
               state_in        = S_RESP;
            end else if (cmd_ff == CMD_FREE) begin
               dp_cmd.op = DP_LOCATED;
               state_in  = S_F_CHK;
            end else if (dp_status.old_ge_need) begin
               // The chunk already holds the size, so its own address is returned.
               dp_cmd.op       = DP_LOCATED;
               dp_cmd.rsp_load = 1'b1;
               dp_cmd.rsp_sel  = RSP_UNIT;
               state_in        = S_RESP;
            end else begin
               dp_cmd.op = DP_LOCATED;
               state_in  = S_R_CHK;
            end
         end
         // Free: merge the free chunks that follow.
         S_F_CHK: begin
            if (dp_status.below_break) begin
               dp_cmd.op = DP_READ;
               state_in  = S_F_EV;
            end else begin
               state_in = S_F_WR;
            end
         end
         S_F_EV: begin
            if (dp_status.free_nz) begin
               dp_cmd.op = DP_ADD;
               state_in  = S_F_CHK;
            end else begin
               state_in = S_F_WR;
            end
         end
         S_F_WR: begin
            dp_cmd.op       = DP_WR_SUM_FREE;
            dp_cmd.rsp_load = 1'b1;
            state_in        = S_RESP;
         end
         // Reallocate: absorb following free chunks until the size is met.
         S_R_CHK: begin
            if (dp_status.below_break) begin
               dp_cmd.op = DP_READ;
               state_in  = S_R_EV;
            end else begin
               state_in = S_R_MISS;
            end
         end
         S_R_EV: begin
            if (dp_status.free_nz) begin
               dp_cmd.op = DP_ADD;
               state_in  = dp_status.sum_ge_need ? S_SPLIT : S_R_CHK;
            end else begin
               state_in = S_R_MISS;
            end
         end
         S_R_MISS: begin
            dp_cmd.op  = DP_WR_SUM_FREE;
            realloc_in = 1'b1;
            state_in   = S_A_CHK;
         end
         // Failed move: put back the old chunk and the free space after it.
         S_RESTORE: begin
            dp_cmd.op = DP_WR_OLD_USED;
            if (dp_status.can_rest) begin
               state_in = S_REST;
            end else begin
               dp_cmd.rsp_load   = 1'b1;
               dp_cmd.rsp_status = 1'b1;
               state_in          = S_RESP;
            end
         end
         S_REST: begin
            dp_cmd.op         = DP_WR_REST;
            dp_cmd.rsp_load   = 1'b1;
            dp_cmd.rsp_status = 1'b1;
            state_in          = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cmd_ff     <= CMD_ALLOC;
         realloc_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cmd_ff     <= cmd_in;
         realloc_ff <= realloc_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   // Header memory is only read below the break.
   a_read_in_heap: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == DP_READ |-> dp_status.below_break)
      else $error("header read at or above the heap break");

   // Growth only happens when the new chunk fits.
   a_grow_fits: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.op == DP_GROW |-> dp_status.can_grow)
      else $error("heap grown past its limit");

   // Restoring an old chunk only follows a failed reallocate move.
   a_restore_realloc: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESTORE |-> realloc_ff && cmd_ff == CMD_REALLOC)
      else $error("restore outside a reallocate");

   // An accepted item always leads to a result being loaded before it is shown.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_RESP && state_in == S_RESP |-> dp_cmd.rsp_load)
      else $error("result shown without being loaded");
endmodule

// File: design/first_fit_implicit_list_allocator.sv
// Top level of the first-fit implicit-list heap allocator.
// Each step of a walk reads one chunk header once from the single-port header memory.
// A free walks to the chunk and then over the free chunks after it; a failed in-place
// reallocate walks the heap a second time. One item is handled at a time, and the next
// item can be taken in the cycle after the result has been accepted.
// Reset clears the controller and the heap break (empty heap); header memory is not cleared.
`timescale 1ns / 1ps
module first_fit_implicit_list_allocator #(
   parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [16:0] req_request_bytes,
   input  logic [15:0] req_payload_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_address,
   output logic        rsp_status
);
   import ffa_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencing of each item.
   ffa_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_command(req_command),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   // Header memory and arithmetic.
   ffa_datapath #(
      .HEAP_UNITS(HEAP_UNITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_request_bytes  (req_request_bytes),
      .req_payload_address(req_payload_address),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status)
   );
endmodule
